>>> rtl/core/swr_pkg.sv
`timescale 1ns / 1ps
package swr_pkg;

    localparam int COUNT_BITS = 16;
    localparam int REV_BITS   = 16;
    localparam int REV_MAX    = (2 ** REV_BITS) - 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_XTOP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG  = 1'b1;
    localparam logic signed [23:0] XTOP_RESET = 24'sh7FFFFF;
    localparam logic [3:0]         SEG_RESET  = 4'd2;

    // long division: numerator bits, divisor bits, two quotient bits a cycle
    localparam int PROD_W    = 89;
    localparam int DIV_NUM_W = 88;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [23:0] potential;
        logic signed [31:0] current;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [63:0] area_twice;
        logic [15:0]        reversals;
        logic               status;
    } t_out;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TRAP,
        OP_TRI,
        OP_STOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [24:0] dx;
        logic signed [24:0] t;
        logic signed [31:0] y0;
        logic signed [31:0] y1;
        logic               rpt;
        logic               short_of;
        logic [REV_BITS-1:0] rev;
    } t_qent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_MLO,
        S_MHI,
        S_MSUM,
        S_DIV,
        S_INNER,
        S_ACC,
        S_REPORT
    } t_bstate;

    function automatic logic [24:0] mag25(input logic signed [24:0] v);
        return v[24] ? 25'(-v) : 25'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

>>> rtl/core/sweep_reversal_positive_area.sv
`timescale 1ns / 1ps
// channel  | handshake                 | payload
// input    | i_in_valid / o_in_ready   | i_in_data   potential, current, last
// result   | o_out_valid / i_out_ready | o_out_data  area_twice, reversals, status
// config   | i_cfg_we                  | i_cfg_idx, i_cfg_data  (0 xtop, 1 segment_select)
//
// The front takes one sample a cycle while its two-entry queue has room.
// Pairs outside the segment, or with no positive current, cost nothing in the
// back; a pair inside runs through the 32x32 multiplier, and a clipped
// triangle or a stop pair with nonzero dx also through the 2-bit-per-cycle
// long divider; the report of a record takes a state of its own.
// Synchronous active-low reset; no clearing pass. A held result does not stop
// the front or the back until the next report.
module sweep_reversal_positive_area (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  swr_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output swr_pkg::t_out                  o_out_data
);
    import swr_pkg::*;

    logic  q_full, q_push, q_pop, q_valid;
    t_qent q_in, q_out;

    swr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_in)
    );

    swr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_out)
    );

    swr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/swr_queue.sv
`timescale 1ns / 1ps
module swr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swr_pkg::t_qent i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output swr_pkg::t_qent o_data
);
    import swr_pkg::*;

    t_qent      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

>>> rtl/core/swr_front.sv
`timescale 1ns / 1ps
module swr_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  swr_pkg::t_in                     i_in_data,
    input  logic                             i_q_full,
    output logic                             o_push,
    output swr_pkg::t_qent                   o_push_data
);
    import swr_pkg::*;

    localparam int RW = (COUNT_BITS > REV_BITS) ? COUNT_BITS : REV_BITS + 1;

    logic signed [23:0]    r_xtop;
    logic [3:0]            r_seg;
    logic signed [23:0]    r_older_p;
    logic signed [23:0]    r_newer_p;
    logic signed [31:0]    r_older_c;
    logic signed [31:0]    r_newer_c;
    logic signed [24:0]    r_last_diff;
    logic [1:0]            r_seen;
    logic [COUNT_BITS-1:0] r_bp;
    logic                  r_stopped;

    logic                  fire;
    logic signed [24:0]    diff;
    logic                  rev_pt;
    logic                  active;
    logic                  integ;
    logic                  stop;
    logic [COUNT_BITS:0]   seg_next;
    logic [COUNT_BITS-1:0] n_bp;
    logic [RW-1:0]         rev_w;
    t_op                   op;

    assign fire       = i_in_valid && !i_q_full;
    assign o_in_ready = !i_q_full;

    always_comb begin
        diff     = 25'(r_newer_p) - 25'(i_in_data.potential);
        rev_pt   = (r_last_diff > 0 && diff < 0) || (r_last_diff < 0 && diff > 0);
        active   = (r_seen == 2'd2);
        seg_next = (COUNT_BITS + 1)'(r_seg) + (COUNT_BITS + 1)'(1);
        integ    = active && !rev_pt && !r_stopped && ({1'b0, r_bp} == seg_next);
        stop     = !(r_newer_p < r_xtop);
        op       = OP_NONE;
        if (integ) begin
            if (stop) begin
                op = OP_STOP;
            end else if (r_older_c > 0 || r_newer_c > 0) begin
                op = (r_older_c < 0 || r_newer_c < 0) ? OP_TRI : OP_TRAP;
            end
        end
        n_bp  = (active && rev_pt && r_bp != '1) ? r_bp + COUNT_BITS'(1) : r_bp;
        rev_w = RW'(n_bp) - RW'(1);

        o_push_data.op       = op;
        o_push_data.dx       = 25'(r_newer_p) - 25'(r_older_p);
        o_push_data.t        = 25'(r_xtop) - 25'(r_older_p);
        o_push_data.y0       = r_older_c;
        o_push_data.y1       = r_newer_c;
        o_push_data.rpt      = i_in_data.last;
        o_push_data.short_of = ({1'b0, n_bp} < seg_next);
        o_push_data.rev      = (rev_w > RW'(REV_MAX)) ? '1 : rev_w[REV_BITS-1:0];
        o_push = fire && (op != OP_NONE || i_in_data.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtop <= XTOP_RESET;
            r_seg  <= SEG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_XTOP: r_xtop <= i_cfg_data[23:0];
                CFG_SEG:  r_seg  <= i_cfg_data[3:0];
                default:  r_seg  <= r_seg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_p   <= '0;
            r_newer_p   <= '0;
            r_older_c   <= '0;
            r_newer_c   <= '0;
            r_last_diff <= '0;
            r_seen      <= 2'd0;
            r_bp        <= COUNT_BITS'(1);
            r_stopped   <= 1'b0;
        end else if (fire) begin
            if (i_in_data.last) begin
                // record ends: back to the reset picture
                r_older_p   <= '0;
                r_newer_p   <= '0;
                r_older_c   <= '0;
                r_newer_c   <= '0;
                r_last_diff <= '0;
                r_seen      <= 2'd0;
                r_bp        <= COUNT_BITS'(1);
                r_stopped   <= 1'b0;
            end else begin
                r_older_p <= r_newer_p;
                r_older_c <= r_newer_c;
                r_newer_p <= i_in_data.potential;
                r_newer_c <= i_in_data.current;
                if (r_seen != 2'd0) begin
                    r_last_diff <= diff;
                end
                if (r_seen != 2'd2) begin
                    r_seen <= r_seen + 2'd1;
                end
                r_bp <= n_bp;
                if (op == OP_STOP) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/swr_back.sv
`timescale 1ns / 1ps
module swr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  swr_pkg::t_qent i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output swr_pkg::t_out  o_out_data
);
    import swr_pkg::*;

    t_bstate               r_state, n_state;
    t_op                   r_op, n_op;
    logic                  r_rpt, n_rpt;
    logic                  r_short, n_short;
    logic [REV_BITS-1:0]   r_rev, n_rev;
    logic [24:0]           r_a, n_a;
    logic                  r_neg, n_neg;
    logic                  r_qneg, n_qneg;
    logic                  r_stage2, n_stage2;
    logic [31:0]           r_sqy, n_sqy;
    logic [63:0]           r_b, n_b;
    logic [63:0]           r_plo, n_plo;
    logic [63:0]           r_phi, n_phi;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [DIV_DEN_W-1:0]  r_den, n_den;
    logic [DIV_DEN_W-1:0]  r_rem, n_rem;
    logic [DIV_NUM_W-1:0]  r_num, n_num;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic signed [31:0]    r_y0, n_y0;
    logic signed [24:0]    r_t, n_t;
    logic signed [63:0]    r_acc, n_acc;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic [DIV_DEN_W:0]    sh;
    logic signed [32:0]    sum33, dif33, two_y0;
    logic signed [31:0]    ypos, yneg;
    logic [63:0]           q, mag;
    logic signed [63:0]    inner;
    logic signed [65:0]    res;
    logic                  ovf;

    assign mul_p       = mul_a * mul_b;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_pop       = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;  n_op = r_op;  n_rpt = r_rpt;  n_short = r_short;
        n_rev = r_rev;  n_a = r_a;  n_neg = r_neg;  n_qneg = r_qneg;
        n_stage2 = r_stage2;  n_sqy = r_sqy;  n_b = r_b;  n_plo = r_plo;
        n_phi = r_phi;  n_prod = r_prod;  n_den = r_den;  n_rem = r_rem;
        n_num = r_num;  n_cnt = r_cnt;  n_y0 = r_y0;  n_t = r_t;  n_acc = r_acc;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        mul_a = 32'(r_a);
        mul_b = r_b[31:0];
        sh    = '0;
        sum33  = 33'(i_q_data.y0) + 33'(i_q_data.y1);
        dif33  = 33'(i_q_data.y1) - 33'(i_q_data.y0);
        two_y0 = {i_q_data.y0, 1'b0};
        ypos   = i_q_data.y0[31] ? i_q_data.y1 : i_q_data.y0;
        yneg   = i_q_data.y0[31] ? i_q_data.y0 : i_q_data.y1;
        q      = r_num[63:0];
        inner  = 64'($signed({r_y0, 1'b0})) + (r_qneg ? 64'(-q) : 64'(q));
        mag    = (r_op == OP_TRI) ? r_num[63:0] : r_prod[63:0];
        ovf    = (r_op != OP_TRI) && (r_prod[PROD_W-1:64] != '0);
        res    = r_neg ? (66'(r_acc) - 66'(mag)) : (66'(r_acc) + 66'(mag));

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_op     = i_q_data.op;
                    n_rpt    = i_q_data.rpt;
                    n_short  = i_q_data.short_of;
                    n_rev    = i_q_data.rev;
                    n_y0     = i_q_data.y0;
                    n_t      = i_q_data.t;
                    n_stage2 = 1'b1;
                    case (i_q_data.op)
                        OP_TRAP: begin
                            n_a     = mag25(i_q_data.dx);
                            n_b     = 64'(mag33(sum33));
                            n_neg   = i_q_data.dx[24] ^ sum33[32];
                            n_state = S_MLO;
                        end
                        OP_TRI: begin
                            // clipped triangle: |dx| * y^2 / (ypos - yneg)
                            n_a     = mag25(i_q_data.dx);
                            n_neg   = i_q_data.dx[24];
                            n_sqy   = ypos;
                            n_den   = DIV_DEN_W'(33'(ypos) - 33'(yneg));
                            n_state = S_SQ;
                        end
                        OP_STOP: begin
                            n_a = mag25(i_q_data.t);
                            if (i_q_data.dx != '0) begin
                                n_b      = 64'(mag33(dif33));
                                n_den    = DIV_DEN_W'(mag25(i_q_data.dx));
                                n_qneg   = dif33[32] ^ i_q_data.t[24] ^ i_q_data.dx[24];
                                n_stage2 = 1'b0;
                            end else begin
                                n_b   = 64'(mag33(two_y0));
                                n_neg = i_q_data.t[24] ^ two_y0[32];
                            end
                            n_state = S_MLO;
                        end
                        default: begin
                            n_state = i_q_data.rpt ? S_REPORT : S_IDLE;
                        end
                    endcase
                end
            end
            S_SQ: begin
                mul_a   = r_sqy;
                mul_b   = r_sqy;
                n_b     = mul_p;
                n_state = S_MLO;
            end
            S_MLO: begin
                n_plo   = mul_p;
                n_state = S_MHI;
            end
            S_MHI: begin
                mul_b   = r_b[63:32];
                n_phi   = mul_p;
                n_state = S_MSUM;
            end
            S_MSUM: begin
                n_prod = (PROD_W'(r_phi) << 32) + PROD_W'(r_plo);
                n_num  = n_prod[DIV_NUM_W-1:0];
                n_rem  = '0;
                n_cnt  = '0;
                if (r_op == OP_TRI || !r_stage2) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_DIV: begin
                for (int k = 0; k < 2; k++) begin
                    sh    = {n_rem, n_num[DIV_NUM_W-1]};
                    n_num = {n_num[DIV_NUM_W-2:0], 1'b0};
                    if (sh >= {1'b0, r_den}) begin
                        n_rem    = DIV_DEN_W'(sh - {1'b0, r_den});
                        n_num[0] = 1'b1;
                    end else begin
                        n_rem = sh[DIV_DEN_W-1:0];
                    end
                end
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = (r_op == OP_TRI) ? S_ACC : S_INNER;
                end
            end
            S_INNER: begin
                // interpolated height at xtop, then times t
                n_b      = mag64(inner);
                n_neg    = r_t[24] ^ inner[63];
                n_stage2 = 1'b1;
                n_state  = S_MLO;
            end
            S_ACC: begin
                if (ovf) begin
                    n_acc = r_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else if (res[65:63] != 3'b000 && res[65:63] != 3'b111) begin
                    n_acc = res[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    n_acc = res[63:0];
                end
                n_state = r_rpt ? S_REPORT : S_IDLE;
            end
            S_REPORT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.area_twice = r_short ? '0 : r_acc;
                    n_out.reversals  = r_rev;
                    n_out.status     = r_short;
                    n_acc            = '0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_rpt <= n_rpt;  r_short <= n_short;  r_rev <= n_rev;
        r_a <= n_a;  r_neg <= n_neg;  r_qneg <= n_qneg;  r_stage2 <= n_stage2;
        r_sqy <= n_sqy;  r_b <= n_b;  r_plo <= n_plo;  r_phi <= n_phi;
        r_prod <= n_prod;  r_den <= n_den;  r_rem <= n_rem;  r_num <= n_num;
        r_y0 <= n_y0;  r_t <= n_t;  r_out <= n_out;
    end

endmodule

>>> rtl/core/swr_checker.sv
`timescale 1ns / 1ps
module swr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input swr_pkg::t_out i_out_data
);
    import swr_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status |-> i_out_data.area_twice == '0)
        else $error("short record reports nonzero area");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result request right after reset");

endmodule

bind sweep_reversal_positive_area swr_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
